// File: hdl/signed_unsigned_divider_64_macros.svh
// assertion macros used by the checker file sud64_checker.sv
`ifndef SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH

// same-cycle implication, checked outside reset
`define SUD64_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SUD64_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sud64_pkg.sv
`default_nettype none

package sud64_pkg;

  // width of every operand and result field on the ports
  localparam int FIELD_W = 64;

  // default operating width of the divider
  localparam int DATA_WIDTH_DEF = 64;

  // status from the iteration unit to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } sud64_stat_t;

endpackage

`default_nettype wire

// File: hdl/sud64_core.sv
`default_nettype none

module sud64_core #(
  parameter int DATA_WIDTH = sud64_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [DATA_WIDTH-1:0]  dividend,
  input  wire logic [DATA_WIDTH-1:0]  divisor,
  output logic      [DATA_WIDTH-1:0]  quotient,
  output logic      [DATA_WIDTH-1:0]  remainder,
  output sud64_pkg::sud64_stat_t      stat
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [W:0]   partial;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] rem_next;
  logic [W-1:0] quo_next;

  // one restoring step: shift in the next dividend bit, try one subtract
  always_comb begin
    partial  = {rem, quo[W-1]};
    diff     = partial - {1'b0, dvs};
    fits     = ~diff[W];
    rem_next = fits ? diff[W-1:0] : partial[W-1:0];
    quo_next = {quo[W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: hdl/signed_unsigned_divider_64.sv
// 64-bit signed/unsigned divider. An item carries the kind bit in s_axis_tuser
// (0 unsigned, 1 two's complement) and dividend and divisor in s_axis_tdata. One
// shared subtract-and-compare unit produces one quotient bit per cycle. The
// operand magnitudes are registered at acceptance, then ST_START starts the
// unit, DATA_WIDTH restoring steps follow, the finish flag moves the sequencer
// to ST_FIX, and ST_FIX does the quotient sign fix-up and loads the output
// register once it is free. s_axis_tready is low while an item is in flight and
// rises as the result is loaded, so one item is taken at a time; a finished
// result sits in the output register, so the next item can be taken while it
// waits.
// Signed mode returns the remainder of the magnitudes. A zero divisor skips the
// iteration and goes straight to ST_FIX; it sets div_by_zero and returns zero
// quotient and remainder. Operand bits at and above DATA_WIDTH are ignored and
// result bits there are zero.
`default_nettype none

module signed_unsigned_divider_64 #(
  parameter int DATA_WIDTH = sud64_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // dividend [63:0], divisor [127:64]
  input  wire logic [2*sud64_pkg::FIELD_W-1:0]   s_axis_tdata,
  // kind [0]
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // quotient [63:0], remainder [127:64]
  output logic      [2*sud64_pkg::FIELD_W-1:0]   m_axis_tdata,
  // div_by_zero [0]
  output logic                                   m_axis_tuser
);

  localparam int W  = DATA_WIDTH;
  localparam int FW = sud64_pkg::FIELD_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_FIX   = 2'd3;

  logic [1:0]   state;
  logic         neg_q;
  logic         dz;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic         out_valid;
  logic [W-1:0] out_quo;
  logic [W-1:0] out_rem;
  logic         out_dz;

  logic [W-1:0] in_a;
  logic [W-1:0] in_b;
  logic         sign_a;
  logic         sign_b;
  logic [W-1:0] mag_a_in;
  logic [W-1:0] mag_b_in;
  logic         in_fire;
  logic         out_load;
  logic         core_start;
  logic [W-1:0] core_quo;
  logic [W-1:0] core_rem;
  logic [W-1:0] quo_fixed;

  sud64_pkg::sud64_stat_t core_stat;

  always_comb begin
    in_a     = s_axis_tdata[W-1:0];
    in_b     = s_axis_tdata[FW+W-1:FW];
    sign_a   = s_axis_tuser & in_a[W-1];
    sign_b   = s_axis_tuser & in_b[W-1];
    mag_a_in = sign_a ? (~in_a + W'(1)) : in_a;
    mag_b_in = sign_b ? (~in_b + W'(1)) : in_b;
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign core_start    = (state == ST_START);
  assign out_load      = (state == ST_FIX) && (!out_valid || m_axis_tready);

  // quotient sign fix-up; the most negative over minus one wraps here
  assign quo_fixed = neg_q ? (~core_quo + W'(1)) : core_quo;

  sud64_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (core_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .quotient (core_quo),
    .remainder(core_rem),
    .stat     (core_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (in_b == '0) ? ST_FIX : ST_START;
          end
        end
        ST_START: begin
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (core_stat.done) begin
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mag_a <= mag_a_in;
      mag_b <= mag_b_in;
      neg_q <= sign_a ^ sign_b;
      dz    <= (in_b == '0);
    end
    if (out_load) begin
      out_quo <= dz ? '0 : quo_fixed;
      out_rem <= dz ? '0 : core_rem;
      out_dz  <= dz;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {FW'(out_rem), FW'(out_quo)};
  assign m_axis_tuser  = out_dz;

endmodule

`default_nettype wire

// File: hdl/sud64_checker.sv
`default_nettype none

`include "signed_unsigned_divider_64_macros.svh"

module sud64_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [2*sud64_pkg::FIELD_W-1:0] m_axis_tdata,
  input wire logic                            m_axis_tuser
);

  logic in_fire;
  logic out_stall;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // one item in flight at a time
  `SUD64_ASSERT_NEXT(a_busy_after_accept, in_fire, !s_axis_tready, "ready high right after accept")

  // a zero divisor gives zero quotient and remainder
  `SUD64_ASSERT_NOW(a_dz_zero_data, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "div_by_zero with nonzero data")

  // a result held by the sink stays put
  `SUD64_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // no result shows up right after reset
  `SUD64_ASSERT_NOW(a_reset_empty, $fell(rst), !m_axis_tvalid, "result valid after reset")

endmodule

bind signed_unsigned_divider_64 sud64_checker u_sud64_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

// File: tb/sud64_tb_pkg.sv
`timescale 1ns / 1ps

package sud64_tb_pkg;

  // operation carried in tuser
  typedef enum logic {
    DIV_UNSIGNED = 1'b0,
    DIV_SIGNED   = 1'b1
  } div_kind_e;

  typedef struct packed {
    logic [sud64_pkg::FIELD_W-1:0] quotient;
    logic [sud64_pkg::FIELD_W-1:0] remainder;
    logic                          div_by_zero;
  } div_result_t;

endpackage

// File: tb/sud64_result_checker.sv
`timescale 1ns / 1ps

module sud64_result_checker #(
  parameter int DATA_WIDTH = sud64_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  input  wire logic                              s_axis_tready,
  // dividend [63:0], divisor [127:64]
  input  wire logic [2*sud64_pkg::FIELD_W-1:0]   s_axis_tdata,
  // kind [0]
  input  wire logic                              s_axis_tuser,
  input  wire logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // quotient [63:0], remainder [127:64]
  input  wire logic [2*sud64_pkg::FIELD_W-1:0]   m_axis_tdata,
  // div_by_zero [0]
  input  wire logic                              m_axis_tuser,
  output int                                     mismatches,
  output int                                     outstanding
);

  import sud64_tb_pkg::*;

  localparam int FW = sud64_pkg::FIELD_W;

  div_result_t expected_divisions[$];

  function automatic div_result_t divide_operands(div_kind_e kind, logic [FW-1:0] dividend,
                                                  logic [FW-1:0] divisor);
    logic [FW-1:0] mask, n, d, mag_n, mag_d, q, r;
    logic          neg_n, neg_d;
    div_result_t   res;
    mask = {FW{1'b1}} >> (FW - DATA_WIDTH);
    n    = dividend & mask;
    d    = divisor & mask;
    res  = '0;
    if (d == '0) begin
      res.div_by_zero = 1'b1;
      return res;
    end
    neg_n = (kind == DIV_SIGNED) && n[DATA_WIDTH-1];
    neg_d = (kind == DIV_SIGNED) && d[DATA_WIDTH-1];
    mag_n = neg_n ? (-n) & mask : n;
    mag_d = neg_d ? (-d) & mask : d;
    q     = mag_n / mag_d;
    r     = mag_n % mag_d;
    // truncation toward zero; most negative over minus one wraps here
    if (neg_n != neg_d) q = -q;
    res.quotient  = q & mask;
    res.remainder = r & mask;
    return res;
  endfunction

  always @(posedge clk) begin
    div_result_t want;
    if (rst) begin
      expected_divisions.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_divisions.push_back(divide_operands(div_kind_e'(s_axis_tuser),
                                                     s_axis_tdata[FW-1:0],
                                                     s_axis_tdata[2*FW-1:FW]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_divisions.size() == 0) begin
          $error("result item with none expected: quotient %h remainder %h div_by_zero %b",
                 m_axis_tdata[FW-1:0], m_axis_tdata[2*FW-1:FW], m_axis_tuser);
          mismatches++;
        end else begin
          want = expected_divisions.pop_front();
          if (m_axis_tdata[FW-1:0] !== want.quotient) begin
            $error("quotient expected %h actual %h", want.quotient, m_axis_tdata[FW-1:0]);
            mismatches++;
          end
          if (m_axis_tdata[2*FW-1:FW] !== want.remainder) begin
            $error("remainder expected %h actual %h", want.remainder,
                   m_axis_tdata[2*FW-1:FW]);
            mismatches++;
          end
          if (m_axis_tuser !== want.div_by_zero) begin
            $error("div_by_zero expected %b actual %b", want.div_by_zero, m_axis_tuser);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_divisions.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import sud64_tb_pkg::*;

  localparam int FW           = sud64_pkg::FIELD_W;
  localparam int RUN_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_ITEMS = 800;

  localparam logic [FW-1:0] ALL_ONES = {FW{1'b1}};
  localparam logic [FW-1:0] MOST_NEG = {1'b1, {(FW-1){1'b0}}};
  localparam logic [FW-1:0] MAX_POS  = {1'b0, {(FW-1){1'b1}}};

  logic            clk           = 1'b0;
  logic            rst           = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic [2*FW-1:0] s_axis_tdata  = '0;
  logic            s_axis_tuser  = 1'b0;
  logic            m_axis_tready = 1'b0;
  logic            s_axis_tready;
  logic            m_axis_tvalid;
  logic [2*FW-1:0] m_axis_tdata;
  logic            m_axis_tuser;

  int mismatches;
  int outstanding;
  int cycle_cnt;
  bit quiet;

  signed_unsigned_divider_64 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sud64_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  function automatic logic [FW-1:0] pick_operand();
    logic [FW-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       v = '0;
          1:       v = FW'(1);
          2:       v = ALL_ONES;
          3:       v = MOST_NEG;
          default: v = MAX_POS;
        endcase
      end
      1, 2, 3: v = v >> $urandom_range(0, FW-1);
      // small negative values
      4:       v = -(v >> $urandom_range(FW-8, FW-1));
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_division(input div_kind_e kind, input logic [FW-1:0] dividend,
                               input logic [FW-1:0] divisor);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {divisor, dividend};
    s_axis_tuser  <= kind;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // receiver: ready runs broken by stalls, sometimes a long run without any
  initial begin
    int run;
    int stall;
    @(posedge clk);
    forever begin
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unsigned edges and zero divisor
    send_division(DIV_UNSIGNED, FW'(100), FW'(7));
    send_division(DIV_UNSIGNED, ALL_ONES, FW'(1));
    send_division(DIV_UNSIGNED, ALL_ONES, ALL_ONES);
    send_division(DIV_UNSIGNED, '0, ALL_ONES);
    send_division(DIV_UNSIGNED, ALL_ONES, MOST_NEG);
    send_division(DIV_UNSIGNED, FW'(1), FW'(3));
    send_division(DIV_UNSIGNED, FW'(5), '0);
    send_division(DIV_UNSIGNED, ALL_ONES, '0);
    send_division(DIV_UNSIGNED, '0, '0);
    // signed: overflow wrap, sign combinations, zero divisor
    send_division(DIV_SIGNED, MOST_NEG, ALL_ONES);
    send_division(DIV_SIGNED, MOST_NEG, FW'(1));
    send_division(DIV_SIGNED, MOST_NEG, FW'(2));
    send_division(DIV_SIGNED, ALL_ONES, MOST_NEG);
    send_division(DIV_SIGNED, MOST_NEG, MOST_NEG);
    send_division(DIV_SIGNED, -FW'(7), FW'(2));
    send_division(DIV_SIGNED, FW'(7), -FW'(2));
    send_division(DIV_SIGNED, -FW'(7), -FW'(2));
    send_division(DIV_SIGNED, MAX_POS, ALL_ONES);
    send_division(DIV_SIGNED, MAX_POS, MAX_POS);
    send_division(DIV_SIGNED, '0, ALL_ONES);
    send_division(DIV_SIGNED, FW'(12345), MOST_NEG);
    send_division(DIV_SIGNED, MOST_NEG, '0);
    send_division(DIV_SIGNED, ALL_ONES, '0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_division(div_kind_e'($urandom_range(0, 1)), pick_operand(), pick_operand());
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: signed_unsigned_divider_64.f
+incdir+hdl
hdl/sud64_pkg.sv
hdl/sud64_core.sv
hdl/signed_unsigned_divider_64.sv
hdl/sud64_checker.sv
tb/sud64_tb_pkg.sv
tb/sud64_result_checker.sv
tb/testbench.sv
